// File: sv/utrq_pkg.sv
// shared constants and types for the uart transmit / receive ring queues
package utrq_pkg;

    localparam int TX_DEPTH = 256;
    localparam int RX_DEPTH = 32;

    localparam int TX_AW = $clog2(TX_DEPTH);
    localparam int RX_AW = $clog2(RX_DEPTH);
    localparam int TX_CW = $clog2(TX_DEPTH + 1);
    localparam int RX_CW = $clog2(RX_DEPTH + 1);

    typedef enum logic [1:0] {
        OP_PUT     = 2'd0,
        OP_GET     = 2'd1,
        OP_RECV    = 2'd2,
        OP_TX_DONE = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_TX_FULL  = 2'd1,
        ST_RX_EMPTY = 2'd2,
        ST_RX_OVER  = 2'd3
    } t_status;

    typedef struct packed {
        logic load;
        logic exec;
    } t_cmd;

endpackage

// File: sv/uart_tx_rx_ring_queues_unit.sv
// top level of the uart transmit / receive ring queues
//
// Each input word (put, get, received byte, transmit done) gives exactly one
// result word. A word is latched at its accepting edge while the store read
// ports fetch the entries at the read pointers, the next cycle updates the
// rings and forms the result, and the result is valid from the edge after
// that. Ready drops at acceptance and rises again at the edge that takes the
// result, so a new word is accepted only after the last result is taken, and
// a result that waits holds off the next word.
// The transmit store is 256 bytes and the receive store 32 bytes, both
// single-write, single-read memories with registered reads, and their
// contents are not cleared by reset.
module uart_tx_rx_ring_queues_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [1:0]                  i_operation,
    input  logic [7:0]                  i_data_byte,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [1:0]                  o_status,
    output logic [7:0]                  o_read_byte,
    output logic                        o_send_valid,
    output logic [7:0]                  o_send_byte,
    output logic [utrq_pkg::TX_CW-1:0]  o_tx_pending,
    output logic [utrq_pkg::RX_CW-1:0]  o_rx_count
);

    utrq_pkg::t_cmd cmd;

    utrq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    utrq_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_operation  (i_operation),
        .i_data_byte  (i_data_byte),
        .o_status     (o_status),
        .o_read_byte  (o_read_byte),
        .o_send_valid (o_send_valid),
        .o_send_byte  (o_send_byte),
        .o_tx_pending (o_tx_pending),
        .o_rx_count   (o_rx_count)
    );

endmodule

// File: sv/utrq_ctrl.sv
// handshake controller: accept, execute, then hold the result word
module utrq_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output utrq_pkg::t_cmd  o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_OUT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_in_ready;
    logic   n_in_ready;
    logic   r_out_valid;
    logic   n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_in_ready  = r_in_ready;
        n_out_valid = r_out_valid;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state    = S_EXEC;
                    n_in_ready = 1'b0;
                end
            end
            S_EXEC: begin
                n_state     = S_OUT;
                n_out_valid = 1'b1;
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b0;
                    n_in_ready  = 1'b1;
                end
            end
            default: begin
                n_state     = S_IDLE;
                n_in_ready  = 1'b1;
                n_out_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_in_ready  <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_in_ready  <= n_in_ready;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = r_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_cmd.load  = i_in_valid & r_in_ready;
    assign o_cmd.exec  = (r_state == S_EXEC);

endmodule

// File: sv/utrq_dpath.sv
// datapath: both ring stores, their pointers and counts, and the result registers
module utrq_dpath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  utrq_pkg::t_cmd              i_cmd,
    input  logic [1:0]                  i_operation,
    input  logic [7:0]                  i_data_byte,
    output logic [1:0]                  o_status,
    output logic [7:0]                  o_read_byte,
    output logic                        o_send_valid,
    output logic [7:0]                  o_send_byte,
    output logic [utrq_pkg::TX_CW-1:0]  o_tx_pending,
    output logic [utrq_pkg::RX_CW-1:0]  o_rx_count
);

    localparam int TXA = utrq_pkg::TX_AW;
    localparam int RXA = utrq_pkg::RX_AW;
    localparam int TXC = utrq_pkg::TX_CW;
    localparam int RXC = utrq_pkg::RX_CW;

    logic [7:0] tx_mem [utrq_pkg::TX_DEPTH];
    logic [7:0] rx_mem [utrq_pkg::RX_DEPTH];

    utrq_pkg::t_op r_op;
    logic [7:0]    r_data;
    logic [7:0]    r_tx_rd;
    logic [7:0]    r_rx_rd;

    logic [TXA-1:0] r_tx_wp, n_tx_wp, r_tx_rp, n_tx_rp;
    logic [TXC-1:0] r_tx_cnt, n_tx_cnt;
    logic [RXA-1:0] r_rx_wp, n_rx_wp, r_rx_rp, n_rx_rp;
    logic [RXC-1:0] r_rx_fill, n_rx_fill;

    utrq_pkg::t_status r_status, n_status;
    logic [7:0]        r_read_byte, n_read_byte;
    logic              r_send_valid, n_send_valid;
    logic [7:0]        r_send_byte, n_send_byte;

    logic tx_we;
    logic rx_we;

    always_comb begin
        n_tx_wp      = r_tx_wp;
        n_tx_rp      = r_tx_rp;
        n_tx_cnt     = r_tx_cnt;
        n_rx_wp      = r_rx_wp;
        n_rx_rp      = r_rx_rp;
        n_rx_fill    = r_rx_fill;
        n_status     = utrq_pkg::ST_OK;
        n_read_byte  = 8'h00;
        n_send_valid = 1'b0;
        n_send_byte  = 8'h00;
        tx_we        = 1'b0;
        rx_we        = 1'b0;
        unique case (r_op)
            utrq_pkg::OP_PUT: begin
                if (r_tx_cnt >= TXC'(utrq_pkg::TX_DEPTH)) begin
                    n_status = utrq_pkg::ST_TX_FULL;
                end else begin
                    n_tx_cnt = r_tx_cnt + TXC'(1);
                    if (r_tx_cnt == '0) begin
                        // shifter idle: word goes straight out
                        n_send_valid = 1'b1;
                        n_send_byte  = r_data;
                    end else begin
                        tx_we   = 1'b1;
                        n_tx_wp = (r_tx_wp == TXA'(utrq_pkg::TX_DEPTH - 1)) ?
                                  '0 : r_tx_wp + TXA'(1);
                    end
                end
            end
            utrq_pkg::OP_GET: begin
                if (r_rx_fill == '0) begin
                    n_status = utrq_pkg::ST_RX_EMPTY;
                end else begin
                    n_read_byte = r_rx_rd;
                    n_rx_rp     = (r_rx_rp == RXA'(utrq_pkg::RX_DEPTH - 1)) ?
                                  '0 : r_rx_rp + RXA'(1);
                    n_rx_fill   = r_rx_fill - RXC'(1);
                end
            end
            utrq_pkg::OP_RECV: begin
                if (r_rx_fill >= RXC'(utrq_pkg::RX_DEPTH)) begin
                    n_status = utrq_pkg::ST_RX_OVER;
                end else begin
                    rx_we     = 1'b1;
                    n_rx_wp   = (r_rx_wp == RXA'(utrq_pkg::RX_DEPTH - 1)) ?
                                '0 : r_rx_wp + RXA'(1);
                    n_rx_fill = r_rx_fill + RXC'(1);
                end
            end
            utrq_pkg::OP_TX_DONE: begin
                if (r_tx_cnt != '0) begin
                    n_tx_cnt = r_tx_cnt - TXC'(1);
                    // more than one pending: next queued word to the shifter
                    if (r_tx_cnt != TXC'(1)) begin
                        n_send_valid = 1'b1;
                        n_send_byte  = r_tx_rd;
                        n_tx_rp      = (r_tx_rp == TXA'(utrq_pkg::TX_DEPTH - 1)) ?
                                       '0 : r_tx_rp + TXA'(1);
                    end
                end
            end
            default: begin
                n_status = utrq_pkg::ST_OK;
            end
        endcase
    end

    // stores; read data tracks the read pointers, settled before execute
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && tx_we) begin
            tx_mem[r_tx_wp] <= r_data;
        end
        r_tx_rd <= tx_mem[r_tx_rp];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && rx_we) begin
            rx_mem[r_rx_wp] <= r_data;
        end
        r_rx_rd <= rx_mem[r_rx_rp];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= utrq_pkg::t_op'(i_operation);
            r_data <= i_data_byte;
        end
        if (i_cmd.exec) begin
            r_status     <= n_status;
            r_read_byte  <= n_read_byte;
            r_send_valid <= n_send_valid;
            r_send_byte  <= n_send_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx_wp   <= '0;
            r_tx_rp   <= '0;
            r_tx_cnt  <= '0;
            r_rx_wp   <= '0;
            r_rx_rp   <= '0;
            r_rx_fill <= '0;
        end else if (i_cmd.exec) begin
            r_tx_wp   <= n_tx_wp;
            r_tx_rp   <= n_tx_rp;
            r_tx_cnt  <= n_tx_cnt;
            r_rx_wp   <= n_rx_wp;
            r_rx_rp   <= n_rx_rp;
            r_rx_fill <= n_rx_fill;
        end
    end

    assign o_status     = r_status;
    assign o_read_byte  = r_read_byte;
    assign o_send_valid = r_send_valid;
    assign o_send_byte  = r_send_byte;
    assign o_tx_pending = r_tx_cnt;
    assign o_rx_count   = r_rx_fill;

endmodule

// File: bench/uart_tx_rx_ring_queues_checker.sv
// checker for the uart ring queues: predicts every result word and compares it
`timescale 1ns / 100ps
module uart_tx_rx_ring_queues_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_ready,
    input  logic [1:0]                  i_operation,
    input  logic [7:0]                  i_data_byte,
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  logic [1:0]                  i_status,
    input  logic [7:0]                  i_read_byte,
    input  logic                        i_send_valid,
    input  logic [7:0]                  i_send_byte,
    input  logic [utrq_pkg::TX_CW-1:0]  i_tx_pending,
    input  logic [utrq_pkg::RX_CW-1:0]  i_rx_count,
    output int                          o_fail_count,
    output int                          o_words_owed
);

    localparam int TXA = utrq_pkg::TX_AW;
    localparam int RXA = utrq_pkg::RX_AW;
    localparam int TXC = utrq_pkg::TX_CW;
    localparam int RXC = utrq_pkg::RX_CW;

    typedef struct {
        utrq_pkg::t_status status;
        logic [7:0]        read_byte;
        logic              send_valid;
        logic [7:0]        send_byte;
        logic [TXC-1:0]    tx_pending;
        logic [RXC-1:0]    rx_count;
    } t_ring_result;

    logic [7:0]     tx_ring [utrq_pkg::TX_DEPTH];
    logic [7:0]     rx_ring [utrq_pkg::RX_DEPTH];
    logic [TXA-1:0] tx_wr, tx_rd;
    logic [RXA-1:0] rx_wr, rx_rd;
    int             tx_level, rx_level;
    int             fails = 0;
    t_ring_result   owed_q [$];
    t_ring_result   head;

    // advances the shadow rings by one word and returns the result it gives
    function automatic t_ring_result advance_rings(utrq_pkg::t_op op, logic [7:0] din);
        t_ring_result r;
        r.status     = utrq_pkg::ST_OK;
        r.read_byte  = 8'h00;
        r.send_valid = 1'b0;
        r.send_byte  = 8'h00;
        case (op)
            utrq_pkg::OP_PUT: begin
                if (tx_level >= utrq_pkg::TX_DEPTH) begin
                    r.status = utrq_pkg::ST_TX_FULL;
                end else begin
                    tx_level++;
                    // nothing in flight: goes straight to the shifter
                    if (tx_level == 1) begin
                        r.send_valid = 1'b1;
                        r.send_byte  = din;
                    end else begin
                        tx_ring[tx_wr] = din;
                        tx_wr = (tx_wr == TXA'(utrq_pkg::TX_DEPTH - 1)) ? '0 : tx_wr + TXA'(1);
                    end
                end
            end
            utrq_pkg::OP_GET: begin
                if (rx_level == 0) begin
                    r.status = utrq_pkg::ST_RX_EMPTY;
                end else begin
                    r.read_byte = rx_ring[rx_rd];
                    rx_rd = (rx_rd == RXA'(utrq_pkg::RX_DEPTH - 1)) ? '0 : rx_rd + RXA'(1);
                    rx_level--;
                end
            end
            utrq_pkg::OP_RECV: begin
                if (rx_level >= utrq_pkg::RX_DEPTH) begin
                    r.status = utrq_pkg::ST_RX_OVER;
                end else begin
                    rx_ring[rx_wr] = din;
                    rx_wr = (rx_wr == RXA'(utrq_pkg::RX_DEPTH - 1)) ? '0 : rx_wr + RXA'(1);
                    rx_level++;
                end
            end
            default: begin
                if (tx_level != 0) begin
                    tx_level--;
                    if (tx_level != 0) begin
                        r.send_valid = 1'b1;
                        r.send_byte  = tx_ring[tx_rd];
                        tx_rd = (tx_rd == TXA'(utrq_pkg::TX_DEPTH - 1)) ? '0 : tx_rd + TXA'(1);
                    end
                end
            end
        endcase
        r.tx_pending = TXC'(tx_level);
        r.rx_count   = RXC'(rx_level);
        return r;
    endfunction

    task automatic match_field(string name, logic [8:0] want, logic [8:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tx_wr    = '0;
            tx_rd    = '0;
            tx_level = 0;
            rx_wr    = '0;
            rx_rd    = '0;
            rx_level = 0;
            owed_q.delete();
        end else begin
            // compare first so a word taken on this edge never meets its own result
            if (i_out_valid && i_out_ready) begin
                if (owed_q.size() == 0) begin
                    $error("result word with nothing expected");
                    fails++;
                end else begin
                    head = owed_q.pop_front();
                    match_field("status", 9'(head.status), 9'(i_status));
                    match_field("read_byte", 9'(head.read_byte), 9'(i_read_byte));
                    match_field("send_valid", 9'(head.send_valid), 9'(i_send_valid));
                    match_field("send_byte", 9'(head.send_byte), 9'(i_send_byte));
                    match_field("tx_pending", 9'(head.tx_pending), 9'(i_tx_pending));
                    match_field("rx_count", 9'(head.rx_count), 9'(i_rx_count));
                end
            end
            if (i_in_valid && i_in_ready) begin
                owed_q.push_back(advance_rings(utrq_pkg::t_op'(i_operation), i_data_byte));
            end
        end
        o_words_owed <= owed_q.size();
        o_fail_count <= fails;
    end

endmodule

// File: bench/uart_tx_rx_ring_queues_unit_tb.sv
// testbench top for the uart ring queues: stimulus, output stalls and verdict
`timescale 1ns / 100ps
module uart_tx_rx_ring_queues_unit_tb;

    localparam int WORD_TARGET = 850;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_AT     = 100;
    localparam int HOLD_CYCLES = 300;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_in_valid;
    logic                        o_in_ready;
    logic [1:0]                  i_operation;
    logic [7:0]                  i_data_byte;
    logic                        o_out_valid;
    logic                        i_out_ready;
    logic [1:0]                  o_status;
    logic [7:0]                  o_read_byte;
    logic                        o_send_valid;
    logic [7:0]                  o_send_byte;
    logic [utrq_pkg::TX_CW-1:0]  o_tx_pending;
    logic [utrq_pkg::RX_CW-1:0]  o_rx_count;

    int fails;
    int owed;
    int cycles = 0;
    int words_sent = 0;
    bit sender_quiet = 1'b0;

    uart_tx_rx_ring_queues_unit u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_operation  (i_operation),
        .i_data_byte  (i_data_byte),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_status     (o_status),
        .o_read_byte  (o_read_byte),
        .o_send_valid (o_send_valid),
        .o_send_byte  (o_send_byte),
        .o_tx_pending (o_tx_pending),
        .o_rx_count   (o_rx_count)
    );

    uart_tx_rx_ring_queues_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_operation  (i_operation),
        .i_data_byte  (i_data_byte),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_status     (o_status),
        .i_read_byte  (o_read_byte),
        .i_send_valid (o_send_valid),
        .i_send_byte  (o_send_byte),
        .i_tx_pending (o_tx_pending),
        .i_rx_count   (o_rx_count),
        .o_fail_count (fails),
        .o_words_owed (owed)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic offer_word(utrq_pkg::t_op op, logic [7:0] din);
        int gap;
        gap = sender_quiet ? 0 : $urandom_range(15, 0);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_operation <= op;
        i_data_byte <= din;
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
        words_sent++;
    endtask

    // sender goes idle until every outstanding result word has come back
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (owed != 0);
    endtask

    function automatic utrq_pkg::t_op rx_side_op();
        return ($urandom_range(1, 0) == 1) ? utrq_pkg::OP_GET : utrq_pkg::OP_RECV;
    endfunction

    // receiver: random stalls, quiet stretches and one long hold-off
    initial begin
        int n;
        int taken;
        bit quiet;
        taken = 0;
        quiet = 1'b0;
        i_out_ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (taken % 32 == 0) quiet = ($urandom_range(3, 0) == 0);
            if (taken == HOLD_AT) n = HOLD_CYCLES;
            else if (quiet) n = 0;
            else n = $urandom_range(15, 0);
            if (n > 0) begin
                i_out_ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_out_valid && i_out_ready));
            taken++;
        end
    end

    initial begin
        utrq_pkg::t_op dir_ops [20];
        logic [7:0]    dir_data [20];
        int            k;
        int            sel;
        dir_ops = '{utrq_pkg::OP_GET, utrq_pkg::OP_TX_DONE, utrq_pkg::OP_PUT,
                    utrq_pkg::OP_PUT, utrq_pkg::OP_PUT, utrq_pkg::OP_TX_DONE,
                    utrq_pkg::OP_TX_DONE, utrq_pkg::OP_TX_DONE, utrq_pkg::OP_TX_DONE,
                    utrq_pkg::OP_RECV, utrq_pkg::OP_RECV, utrq_pkg::OP_RECV,
                    utrq_pkg::OP_GET, utrq_pkg::OP_GET, utrq_pkg::OP_GET,
                    utrq_pkg::OP_GET, utrq_pkg::OP_GET, utrq_pkg::OP_TX_DONE,
                    utrq_pkg::OP_PUT, utrq_pkg::OP_TX_DONE};
        dir_data = '{8'hff, 8'h00, 8'h00, 8'hff, 8'ha5, 8'h00, 8'h00,
                     8'h00, 8'h00, 8'h00, 8'hff, 8'h5a, 8'h00, 8'h00,
                     8'h00, 8'h00, 8'hff, 8'hff, 8'h80, 8'h00};

        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_operation <= utrq_pkg::OP_PUT;
        i_data_byte <= 8'h00;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // corners: empty get, idle transmit done, direct send, queued sends, receive path
        for (k = 0; k < 20; k++) offer_word(dir_ops[k[4:0]], dir_data[k[4:0]]);
        wait_drained();

        // fill the transmit queue past its depth, then drain it, with rx noise
        sender_quiet = 1'b1;
        for (k = 0; k < 260; k++) begin
            if ($urandom_range(7, 0) == 0) offer_word(rx_side_op(), 8'($urandom_range(255, 0)));
            offer_word(utrq_pkg::OP_PUT, 8'($urandom_range(255, 0)));
            if (k % 64 == 0) sender_quiet = ($urandom_range(1, 0) == 1);
        end
        for (k = 0; k < 260; k++) begin
            if ($urandom_range(7, 0) == 0) offer_word(rx_side_op(), 8'($urandom_range(255, 0)));
            offer_word(utrq_pkg::OP_TX_DONE, 8'($urandom_range(255, 0)));
            if (k % 64 == 0) sender_quiet = ($urandom_range(1, 0) == 1);
        end
        wait_drained();

        while (words_sent < WORD_TARGET) begin
            sender_quiet = ($urandom_range(3, 0) == 0);
            sel = $urandom_range(9, 0);
            if (sel < 2) begin
                // overrun the receive queue, then read it dry
                for (k = 0; k < 34; k++) offer_word(utrq_pkg::OP_RECV, 8'($urandom_range(255, 0)));
                for (k = 0; k < 35; k++) offer_word(utrq_pkg::OP_GET, 8'($urandom_range(255, 0)));
            end else begin
                for (k = 0; k < 20; k++) begin
                    offer_word(utrq_pkg::t_op'($urandom_range(3, 0)),
                               8'($urandom_range(255, 0)));
                end
            end
            if (sel == 9) wait_drained();
        end

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (fails == 0 && owed == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
